// ===== hdl/led_strip_hue_pattern_generator_assert.svh =====
// Assertion macros used by the RTL of the LED strip pattern generator (lshpg_back).
// All of them sample on clk and are disabled while rst_n is low.
`ifndef LED_STRIP_HUE_PATTERN_GENERATOR_ASSERT_SVH
`define LED_STRIP_HUE_PATTERN_GENERATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSHPG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LSHPG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/lshpg_pkg.sv =====
`timescale 1ns / 1ps

package lshpg_pkg;

    localparam int LED_COUNT  = 57;
    localparam int STRIP_LEN  = (LED_COUNT < 1) ? 1 : ((LED_COUNT > 64) ? 64 : LED_COUNT);
    localparam int IDX_W      = 6;
    localparam int HUE_W      = 9;
    localparam int SEC_DEG    = 43;
    localparam int RAMP_TOP   = 42;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STRIP_LEN - 1);
    localparam logic [HUE_W-1:0] HUE_STEP = HUE_W'(360 / STRIP_LEN);
    localparam logic [HUE_W-1:0] HUE_FULL = HUE_W'(360);

    typedef enum logic [1:0] {
        MODE_SOLID   = 2'd0,
        MODE_RAINBOW = 2'd1,
        MODE_ROTATE  = 2'd2,
        MODE_UNIFORM = 2'd3
    } mode_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    // One classified command as it waits between the front and the back.
    typedef struct packed {
        mode_t            mode;
        rgb_t             color;
        logic [HUE_W-1:0] hue;
    } cmd_t;

    // One finished pixel.
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        rgb_t             color;
        logic             last;
    } pix_t;

    // Hue split into its 43-degree section and the position inside it.
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             last;
        logic             solid;
        rgb_t             color;
        logic [3:0]       sec;
        logic [5:0]       pos;
    } split_t;

    function automatic logic [3:0] hue_section(input logic [HUE_W-1:0] h);
        logic [3:0] s;
        s = '0;
        for (int k = 1; k <= 8; k++) begin
            if (h >= HUE_W'(SEC_DEG * k)) begin
                s = s + 4'd1;
            end
        end
        return s;
    endfunction

    // Ramp value for k = 42 - x; floor(255 * floor(255 * k / 42) / 256)
    // reduces to 6k + floor(k / 14) - 1 for k above zero.
    function automatic logic [7:0] ramp(input logic [5:0] k);
        logic [8:0] v;
        v = 9'(k) * 9'd6;
        if (k >= 6'd14) begin
            v = v + 9'd1;
        end
        if (k >= 6'd28) begin
            v = v + 9'd1;
        end
        if (k >= 6'(RAMP_TOP)) begin
            v = v + 9'd1;
        end
        if (k != 6'd0) begin
            v = v - 9'd1;
        end
        return v[7:0];
    endfunction

    function automatic rgb_t wheel(input logic [3:0] sec, input logic [5:0] pos);
        rgb_t       c;
        logic [7:0] q;
        logic [7:0] t;
        q = ramp(6'(RAMP_TOP) - pos);
        t = ramp(pos);
        case (sec)
            4'd0:    c = '{r: 8'd255, g: t,       b: 8'd0};
            4'd1:    c = '{r: q,       g: 8'd255, b: 8'd0};
            4'd2:    c = '{r: 8'd0,   g: 8'd255, b: t};
            4'd3:    c = '{r: 8'd0,   g: q,       b: 8'd255};
            4'd4:    c = '{r: t,       g: 8'd0,   b: 8'd255};
            4'd5:    c = '{r: 8'd255, g: 8'd0,   b: q};
            default: c = '{r: 8'd255, g: 8'd0,   b: 8'd0};
        endcase
        return c;
    endfunction

endpackage

// ===== hdl/led_strip_hue_pattern_generator.sv =====
`timescale 1ns / 1ps

// LED strip hue pattern generator. Each command pushed in produces one pixel for every LED of
// the strip (57 LEDs), in order from LED 0 up, with last_pixel set on the final one. The
// operation field selects a solid color (red, green and blue taken as given), a fixed rainbow
// where LED i gets hue 6 * i degrees, a rotating rainbow that adds hue_offset to that hue modulo
// 360, or one uniform hue, hue_offset, for all LEDs; offsets from 360 up are reduced modulo 360.
// A hue is mapped to the color wheel in 43-degree sections, and hues from 258 degrees up come
// out pure red. Commands enter a two-entry command queue at the front, so a new command is taken
// while the previous frame is still streaming. The back pulls a command when its pixel sequencer
// is idle or finishes a frame and sends one pixel per clock through a sequencer stage, a hue
// split stage and a two-entry result queue. Consecutive frames run with no gap between them,
// and the first pixel of a command passes through the command queue, the sequencer stage and
// the hue split stage into the result queue before it appears on the result ports. When the
// result queue fills because pop is held low, the whole back stalls and nothing is lost.

module led_strip_hue_pattern_generator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [1:0]                  operation,
    input  logic [7:0]                  red,
    input  logic [7:0]                  green,
    input  logic [7:0]                  blue,
    input  logic [lshpg_pkg::HUE_W-1:0] hue_offset,
    output logic                        empty,
    input  logic                        pop,
    output logic [lshpg_pkg::IDX_W-1:0] led_index,
    output logic [7:0]                  pixel_red,
    output logic [7:0]                  pixel_green,
    output logic [7:0]                  pixel_blue,
    output logic                        last_pixel
);

    // Command handoff between the front queue and the pixel sequencer.
    logic            cmd_valid;
    lshpg_pkg::cmd_t cmd;
    logic            cmd_pop;

    // Pixel handoff between the color stage and the result queue.
    logic            pix_wr;
    lshpg_pkg::pix_t pix_in;
    logic            pix_full;
    lshpg_pkg::pix_t pix_out;

    lshpg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .operation  (operation),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .hue_offset (hue_offset),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop)
    );

    lshpg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .pix_wr    (pix_wr),
        .pix       (pix_in),
        .pix_full  (pix_full)
    );

    lshpg_out_queue u_out_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (pix_wr),
        .wr_pix  (pix_in),
        .wr_full (pix_full),
        .empty   (empty),
        .pop     (pop),
        .rd_pix  (pix_out)
    );

    // The oldest waiting pixel is always presented on the result ports.
    assign led_index   = pix_out.idx;
    assign pixel_red   = pix_out.color.r;
    assign pixel_green = pix_out.color.g;
    assign pixel_blue  = pix_out.color.b;
    assign last_pixel  = pix_out.last;

endmodule

// ===== hdl/lshpg_front.sv =====
`timescale 1ns / 1ps

module lshpg_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [1:0]                    operation,
    input  logic [7:0]                    red,
    input  logic [7:0]                    green,
    input  logic [7:0]                    blue,
    input  logic [lshpg_pkg::HUE_W-1:0]   hue_offset,
    output logic                          cmd_valid,
    output lshpg_pkg::cmd_t               cmd,
    input  logic                          cmd_pop
);

    lshpg_pkg::cmd_t  slot_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             wr_en;
    logic             rd_en;
    lshpg_pkg::cmd_t  classified;

    // Decode the mode and fold the offset into 0..359 on the way in.
    always_comb
    begin
        classified.mode  = lshpg_pkg::mode_t'(operation);
        classified.color = '{r: red, g: green, b: blue};
        if (hue_offset >= lshpg_pkg::HUE_FULL) begin
            classified.hue = hue_offset - lshpg_pkg::HUE_FULL;
        end else begin
            classified.hue = hue_offset;
        end
    end

    assign full      = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign wr_en     = push && !full;
    assign rd_en     = cmd_pop && cmd_valid;

    always_comb
    begin
        wr_ptr_next = wr_en ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = rd_en ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(wr_en) - 2'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            slot_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

// ===== hdl/lshpg_out_queue.sv =====
`timescale 1ns / 1ps

module lshpg_out_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr,
    input  lshpg_pkg::pix_t wr_pix,
    output logic            wr_full,
    output logic            empty,
    input  logic            pop,
    output lshpg_pkg::pix_t rd_pix
);

    lshpg_pkg::pix_t slot_reg [2];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic            wr_en;
    logic            rd_en;

    assign wr_full = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign rd_pix  = slot_reg[rd_ptr_reg];
    assign wr_en   = wr && !wr_full;
    assign rd_en   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_en ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = rd_en ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(wr_en) - 2'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            slot_reg[wr_ptr_reg] <= wr_pix;
        end
    end

endmodule

// ===== hdl/lshpg_back.sv =====
`timescale 1ns / 1ps

`include "led_strip_hue_pattern_generator_assert.svh"

module lshpg_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    input  lshpg_pkg::cmd_t cmd,
    output logic            cmd_pop,
    output logic            pix_wr,
    output lshpg_pkg::pix_t pix,
    input  logic            pix_full
);

    // Pixel sequencer.
    logic                          seq_valid_reg;
    logic                          seq_valid_next;
    logic [lshpg_pkg::IDX_W-1:0]   seq_idx_reg;
    logic [lshpg_pkg::IDX_W-1:0]   seq_idx_next;
    logic [lshpg_pkg::HUE_W-1:0]   seq_hue_reg;
    logic [lshpg_pkg::HUE_W-1:0]   seq_hue_next;
    logic [lshpg_pkg::HUE_W-1:0]   seq_step_reg;
    logic [lshpg_pkg::HUE_W-1:0]   seq_step_next;
    logic                          seq_solid_reg;
    logic                          seq_solid_next;
    lshpg_pkg::rgb_t               seq_color_reg;
    lshpg_pkg::rgb_t               seq_color_next;
    logic                          seq_last;
    logic [lshpg_pkg::HUE_W:0]     hue_sum;
    logic [lshpg_pkg::HUE_W-1:0]   hue_wrapped;
    logic                          adv;

    // Section split stage.
    logic                          st1_valid_reg;
    lshpg_pkg::split_t             st1_reg;
    lshpg_pkg::split_t             st1_next;
    logic [lshpg_pkg::HUE_W-1:0]   sec_base;

    // The whole pipeline holds while the output queue has no room.
    assign adv      = !pix_full;
    assign seq_last = (seq_idx_reg == lshpg_pkg::LAST_IDX);
    assign cmd_pop  = adv && cmd_valid && (!seq_valid_reg || seq_last);

    always_comb
    begin
        hue_sum = {1'b0, seq_hue_reg} + {1'b0, seq_step_reg};
        if (hue_sum >= {1'b0, lshpg_pkg::HUE_FULL}) begin
            hue_wrapped = lshpg_pkg::HUE_W'(hue_sum - {1'b0, lshpg_pkg::HUE_FULL});
        end else begin
            hue_wrapped = hue_sum[lshpg_pkg::HUE_W-1:0];
        end
    end

    always_comb
    begin
        seq_valid_next = seq_valid_reg;
        seq_idx_next   = seq_idx_reg;
        seq_hue_next   = seq_hue_reg;
        seq_step_next  = seq_step_reg;
        seq_solid_next = seq_solid_reg;
        seq_color_next = seq_color_reg;
        if (adv) begin
            if (seq_valid_reg && !seq_last) begin
                seq_idx_next = seq_idx_reg + lshpg_pkg::IDX_W'(1);
                seq_hue_next = hue_wrapped;
            end else if (cmd_valid) begin
                seq_valid_next = 1'b1;
                seq_idx_next   = '0;
                seq_solid_next = (cmd.mode == lshpg_pkg::MODE_SOLID);
                seq_color_next = cmd.color;
                seq_hue_next   = (cmd.mode == lshpg_pkg::MODE_RAINBOW) ? '0 : cmd.hue;
                if (cmd.mode == lshpg_pkg::MODE_RAINBOW || cmd.mode == lshpg_pkg::MODE_ROTATE)
                begin
                    seq_step_next = lshpg_pkg::HUE_STEP;
                end else begin
                    seq_step_next = '0;
                end
            end else begin
                seq_valid_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        st1_next.idx   = seq_idx_reg;
        st1_next.last  = seq_last;
        st1_next.solid = seq_solid_reg;
        st1_next.color = seq_color_reg;
        st1_next.sec   = lshpg_pkg::hue_section(seq_hue_reg);
        sec_base       = lshpg_pkg::HUE_W'(st1_next.sec) * lshpg_pkg::HUE_W'(lshpg_pkg::SEC_DEG);
        st1_next.pos   = 6'(seq_hue_reg - sec_base);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            seq_valid_reg <= 1'b0;
            st1_valid_reg <= 1'b0;
        end else begin
            seq_valid_reg <= seq_valid_next;
            if (adv) begin
                st1_valid_reg <= seq_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        seq_idx_reg   <= seq_idx_next;
        seq_hue_reg   <= seq_hue_next;
        seq_step_reg  <= seq_step_next;
        seq_solid_reg <= seq_solid_next;
        seq_color_reg <= seq_color_next;
        if (adv) begin
            st1_reg <= st1_next;
        end
    end

    // Color stage feeds the output queue directly.
    assign pix_wr = adv && st1_valid_reg;

    always_comb
    begin
        pix.idx  = st1_reg.idx;
        pix.last = st1_reg.last;
        if (st1_reg.solid) begin
            pix.color = st1_reg.color;
        end else begin
            pix.color = lshpg_pkg::wheel(st1_reg.sec, st1_reg.pos);
        end
    end

    `LSHPG_ASSERT_NOW(a_hue_range, seq_valid_reg, seq_hue_reg < lshpg_pkg::HUE_FULL,
        "hue out of range")
    `LSHPG_ASSERT_NOW(a_pop_on_end, cmd_pop, !seq_valid_reg || seq_last,
        "command taken mid frame")
    `LSHPG_ASSERT_NEXT(a_idx_step, seq_valid_reg && adv && !seq_last,
        seq_valid_reg && seq_idx_reg == $past(seq_idx_reg) + lshpg_pkg::IDX_W'(1),
        "pixel index skipped")
    `LSHPG_ASSERT_NEXT(a_stall_hold, st1_valid_reg && !adv,
        st1_valid_reg && $stable(st1_reg), "stalled pixel changed")

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    // Hue arithmetic of the color wheel.
    localparam int DEG_FULL    = 360;
    localparam int SECTION_DEG = 43;
    localparam int RAMP_SPAN   = 42;
    localparam int RAMP_BASE   = 10710;
    localparam int LEVEL_MAX   = 255;
    localparam int HUE_MAX     = (1 << lshpg_pkg::HUE_W) - 1;

    // Both sides stop idling inside this window of cycles.
    localparam int CALM_FROM   = 6000;
    localparam int CALM_TO     = 10000;
    localparam int IDLE_PCT    = 14;
    localparam int RANDOM_CMDS = 288;
    localparam int MAX_REPORTS = 10;
    localparam int DRAIN_WAIT  = 20;

    // One strip command as it sits in the stimulus queue.
    typedef struct packed {
        lshpg_pkg::mode_t            mode;
        logic [7:0]                  r;
        logic [7:0]                  g;
        logic [7:0]                  b;
        logic [lshpg_pkg::HUE_W-1:0] hue;
    } strip_cmd_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                        push = 1'b0;
    logic                        full;
    logic [1:0]                  operation = '0;
    logic [7:0]                  red = '0;
    logic [7:0]                  green = '0;
    logic [7:0]                  blue = '0;
    logic [lshpg_pkg::HUE_W-1:0] hue_offset = '0;
    logic                        empty;
    logic                        pop = 1'b0;
    logic [lshpg_pkg::IDX_W-1:0] led_index;
    logic [7:0]                  pixel_red;
    logic [7:0]                  pixel_green;
    logic [7:0]                  pixel_blue;
    logic                        last_pixel;

    strip_cmd_t      pending_cmds[$];
    lshpg_pkg::pix_t expected_pixels[$];

    int cycle_count = 0;
    int fail_count = 0;
    int pixels_checked = 0;
    int frames_sent[4] = '{0, 0, 0, 0};

    led_strip_hue_pattern_generator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .operation   (operation),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .hue_offset  (hue_offset),
        .empty       (empty),
        .pop         (pop),
        .led_index   (led_index),
        .pixel_red   (pixel_red),
        .pixel_green (pixel_green),
        .pixel_blue  (pixel_blue),
        .last_pixel  (last_pixel)
    );

    initial
    begin
        forever
        begin
            #2 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Random idling at about 14 percent, switched off inside the calm window so
    // that a long run of back-to-back transfers is also exercised.
    function automatic bit take_break();
        if (cycle_count >= CALM_FROM && cycle_count < CALM_TO)
        begin
            return 1'b0;
        end
        return $urandom_range(99) < IDLE_PCT;
    endfunction

    // Integer ramp of the color wheel: falls from 254 at position 0 to 0 at the
    // far end of a section. Rising ramps use it with the position mirrored.
    function automatic logic [7:0] ramp_level(input int x);
        return 8'((LEVEL_MAX * ((RAMP_BASE - LEVEL_MAX * x) / RAMP_SPAN)) / 256);
    endfunction

    // Maps a hue in degrees, any size, onto the wheel. Sections six to eight
    // (hues from 258 up) are not part of the wheel proper and give pure red.
    function automatic lshpg_pkg::rgb_t wheel_color(input int hue);
        int              h;
        int              section;
        int              pos;
        logic [7:0]      fall;
        logic [7:0]      rise;
        lshpg_pkg::rgb_t c;
        h       = hue % DEG_FULL;
        section = h / SECTION_DEG;
        pos     = h % SECTION_DEG;
        fall    = ramp_level(pos);
        rise    = ramp_level(RAMP_SPAN - pos);
        case (section)
            0:       c = '{r: 8'd255, g: rise,    b: 8'd0};
            1:       c = '{r: fall,   g: 8'd255, b: 8'd0};
            2:       c = '{r: 8'd0,   g: 8'd255, b: rise};
            3:       c = '{r: 8'd0,   g: fall,    b: 8'd255};
            4:       c = '{r: rise,   g: 8'd0,   b: 8'd255};
            5:       c = '{r: 8'd255, g: 8'd0,   b: fall};
            default: c = '{r: 8'd255, g: 8'd0,   b: 8'd0};
        endcase
        return c;
    endfunction

    // Expands one accepted command into the pixels of a whole strip frame.
    task automatic expand_frame(input strip_cmd_t c);
        int              hue_step;
        lshpg_pkg::pix_t p;
        hue_step = DEG_FULL / lshpg_pkg::STRIP_LEN;
        for (int i = 0; i < lshpg_pkg::STRIP_LEN; i++)
        begin
            p.idx  = lshpg_pkg::IDX_W'(i);
            p.last = (i == lshpg_pkg::STRIP_LEN - 1);
            case (c.mode)
                lshpg_pkg::MODE_SOLID:   p.color = '{r: c.r, g: c.g, b: c.b};
                lshpg_pkg::MODE_RAINBOW: p.color = wheel_color(hue_step * i);
                lshpg_pkg::MODE_ROTATE:  p.color = wheel_color(hue_step * i + int'(c.hue));
                default:                 p.color = wheel_color(int'(c.hue));
            endcase
            expected_pixels.push_back(p);
        end
    endtask

    // Counts a failure and prints the first few of them.
    task automatic report_failure(input string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
        begin
            $display("[%0t] ERROR: %s", $realtime, what);
        end
    endtask

    // Command driver. A transfer happens at an edge where push is high and full
    // is low; the values on the ports at that edge are the accepted command, and
    // its frame is predicted right away. A command that has not been taken yet
    // stays on the ports. Otherwise the next one is offered unless this cycle
    // is an idle one.
    always @(posedge clk or negedge rst_n)
    begin
        strip_cmd_t taken_cmd;
        bit         taken;
        if (!rst_n)
        begin
            push       <= 1'b0;
            operation  <= '0;
            red        <= '0;
            green      <= '0;
            blue       <= '0;
            hue_offset <= '0;
        end
        else
        begin
            taken = push && !full;
            if (taken)
            begin
                taken_cmd = '{mode: lshpg_pkg::mode_t'(operation), r: red, g: green,
                              b: blue, hue: hue_offset};
                expand_frame(taken_cmd);
                frames_sent[operation]++;
                void'(pending_cmds.pop_front());
            end
            if (push && !taken)
            begin
                push <= 1'b1;
            end
            else if (pending_cmds.size() > 0 && !take_break())
            begin
                push       <= 1'b1;
                operation  <= pending_cmds[0].mode;
                red        <= pending_cmds[0].r;
                green      <= pending_cmds[0].g;
                blue       <= pending_cmds[0].b;
                hue_offset <= pending_cmds[0].hue;
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    // Pixel monitor. A pixel transfers at an edge where pop is high and empty is
    // low; it is checked against the oldest expected pixel. Pop itself is
    // dropped at random to stall the result side.
    always @(posedge clk or negedge rst_n)
    begin
        lshpg_pkg::pix_t want;
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_pixels.size() == 0)
                begin
                    report_failure($sformatf(
                        "pixel with nothing expected: idx %0d rgb %0d,%0d,%0d last %0b",
                        led_index, pixel_red, pixel_green, pixel_blue, last_pixel));
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    pixels_checked++;
                    if (led_index !== want.idx || pixel_red !== want.color.r ||
                        pixel_green !== want.color.g || pixel_blue !== want.color.b ||
                        last_pixel !== want.last)
                    begin
                        report_failure({
                            $sformatf("pixel mismatch: expected idx %0d rgb %0d,%0d,%0d",
                                      want.idx, want.color.r, want.color.g,
                                      want.color.b),
                            $sformatf(" last %0b, got idx %0d rgb %0d,%0d,%0d last %0b",
                                      want.last, led_index, pixel_red, pixel_green,
                                      pixel_blue, last_pixel)});
                    end
                end
            end
            pop <= !take_break();
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int         hue_pick;
        strip_cmd_t rnd_cmd;
        // Solid colors at the extremes and with alternating bit patterns.
        pending_cmds.push_back('{lshpg_pkg::MODE_SOLID, 8'h00, 8'h00, 8'h00, 9'd0});
        pending_cmds.push_back('{lshpg_pkg::MODE_SOLID, 8'hFF, 8'hFF, 8'hFF, 9'd511});
        pending_cmds.push_back('{lshpg_pkg::MODE_SOLID, 8'hAA, 8'h55, 8'hF0, 9'd170});
        pending_cmds.push_back('{lshpg_pkg::MODE_SOLID, 8'h55, 8'hAA, 8'h0F, 9'd341});
        // Rainbow, plain and with the color and offset fields that it must ignore set.
        pending_cmds.push_back('{lshpg_pkg::MODE_RAINBOW, 8'h00, 8'h00, 8'h00, 9'd0});
        pending_cmds.push_back('{lshpg_pkg::MODE_RAINBOW, 8'hFF, 8'h12, 8'h80, 9'd511});
        // Rotating rainbow around section edges, the pure red range and the
        // offsets past 359 that wrap.
        pending_cmds.push_back('{lshpg_pkg::MODE_ROTATE, 8'h00, 8'h00, 8'h00, 9'd0});
        pending_cmds.push_back('{lshpg_pkg::MODE_ROTATE, 8'h00, 8'h00, 8'h00, 9'd42});
        pending_cmds.push_back('{lshpg_pkg::MODE_ROTATE, 8'h00, 8'h00, 8'h00, 9'd43});
        pending_cmds.push_back('{lshpg_pkg::MODE_ROTATE, 8'h00, 8'h00, 8'h00, 9'd258});
        pending_cmds.push_back('{lshpg_pkg::MODE_ROTATE, 8'hFF, 8'hFF, 8'hFF, 9'd359});
        pending_cmds.push_back('{lshpg_pkg::MODE_ROTATE, 8'h00, 8'h00, 8'h00, 9'd360});
        pending_cmds.push_back('{lshpg_pkg::MODE_ROTATE, 8'h00, 8'h00, 8'h00, 9'd511});
        // Uniform hue at both ends of sections, the red tail and wrapped values.
        pending_cmds.push_back('{lshpg_pkg::MODE_UNIFORM, 8'h00, 8'h00, 8'h00, 9'd0});
        pending_cmds.push_back('{lshpg_pkg::MODE_UNIFORM, 8'h00, 8'h00, 8'h00, 9'd42});
        pending_cmds.push_back('{lshpg_pkg::MODE_UNIFORM, 8'h00, 8'h00, 8'h00, 9'd43});
        pending_cmds.push_back('{lshpg_pkg::MODE_UNIFORM, 8'h00, 8'h00, 8'h00, 9'd257});
        pending_cmds.push_back('{lshpg_pkg::MODE_UNIFORM, 8'h00, 8'h00, 8'h00, 9'd258});
        pending_cmds.push_back('{lshpg_pkg::MODE_UNIFORM, 8'hFF, 8'hFF, 8'hFF, 9'd359});
        pending_cmds.push_back('{lshpg_pkg::MODE_UNIFORM, 8'h00, 8'h00, 8'h00, 9'd360});
        pending_cmds.push_back('{lshpg_pkg::MODE_UNIFORM, 8'h00, 8'h00, 8'h00, 9'd402});
        pending_cmds.push_back('{lshpg_pkg::MODE_UNIFORM, 8'h00, 8'h00, 8'h00, 9'd511});

        // Random commands. Most hues are drawn over the whole 9-bit field; some
        // land on a section boundary, where the ramps turn over.
        for (int n = 0; n < RANDOM_CMDS; n++)
        begin
            if ($urandom_range(3) == 0)
            begin
                hue_pick = SECTION_DEG * $urandom_range(11) + $urandom_range(1) * RAMP_SPAN;
                hue_pick = hue_pick > HUE_MAX ? HUE_MAX : hue_pick;
            end
            else
            begin
                hue_pick = $urandom_range(HUE_MAX);
            end
            rnd_cmd.mode = lshpg_pkg::mode_t'($urandom_range(3));
            rnd_cmd.r    = 8'($urandom_range(255));
            rnd_cmd.g    = 8'($urandom_range(255));
            rnd_cmd.b    = 8'($urandom_range(255));
            rnd_cmd.hue  = lshpg_pkg::HUE_W'(hue_pick);
            pending_cmds.push_back(rnd_cmd);
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for the last command transfer, then for its pixels to drain.
        // Sampling at the falling edge keeps clear of the clocked blocks.
        do
        begin
            @(negedge clk);
        end
        while (pending_cmds.size() > 0 || push);
        while (expected_pixels.size() > 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_WAIT) @(negedge clk);
        if (expected_pixels.size() > 0)
        begin
            report_failure($sformatf("%0d expected pixels never arrived",
                                     expected_pixels.size()));
        end

        $display("Run covered %0d solid, %0d rainbow, %0d rotating and %0d uniform frames,",
                 frames_sent[lshpg_pkg::MODE_SOLID], frames_sent[lshpg_pkg::MODE_RAINBOW],
                 frames_sent[lshpg_pkg::MODE_ROTATE], frames_sent[lshpg_pkg::MODE_UNIFORM]);
        $display("with %0d pixels checked and %0d failures.", pixels_checked, fail_count);
        if (fail_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog: a correct run ends far sooner than this.
    initial
    begin
        #2000000;
        $display("Timeout: %0d expected pixels still waiting", expected_pixels.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
